// File: src/fpsc_pkg.sv
`timescale 1ns / 1ps

package fpsc_pkg;

	localparam int STEP_W = 3;

	// configuration register indexes
	localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [1:0] REG_ALPHA      = 2'd2;
	localparam logic [1:0] REG_LIMIT      = 2'd3;

	localparam logic [23:0] PROP_GAIN_RST  = 24'd61440;
	localparam logic [23:0] INTEG_GAIN_RST = 24'd307;
	localparam logic [8:0]  ALPHA_RST      = 9'd77;
	localparam logic [15:0] LIMIT_RST      = 16'd3000;
	localparam logic [8:0]  ALPHA_ONE      = 9'd256;

	localparam logic [31:0] DRIVE_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] DRIVE_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		OP_WAIT_IN  = 3'd0,
		OP_MUL      = 3'd1,
		OP_FILT     = 3'd2,
		OP_INTEG    = 3'd3,
		OP_MUL_LOAD = 3'd4,
		OP_ACC_ADD  = 3'd5,
		OP_EMIT     = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE     = 2'd0,
		COND_NO_INPUT = 2'd1,
		COND_OUT_FULL = 2'd2
	} cond_t;

	typedef enum logic [1:0] {
		A_ALPHA = 2'd0,
		A_KP    = 2'd1,
		A_KI    = 2'd2
	} a_sel_t;

	typedef enum logic [1:0] {
		B_DIFF  = 2'd0,
		B_FILT  = 2'd1,
		B_INTEG = 2'd2
	} b_sel_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              mul_en;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_full;
	} stat_t;

	// microprogram: one control word per step
	function automatic ctrl_t fpsc_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{op: OP_MUL, cond: COND_NONE, target: '0, mul_en: 1'b0,
			a_sel: A_ALPHA, b_sel: B_DIFF};
		case (step)
			3'd0: begin
				w.op = OP_WAIT_IN; w.cond = COND_NO_INPUT; w.target = 3'd0;
			end
			3'd1: begin
				w.op = OP_MUL; w.mul_en = 1'b1; w.a_sel = A_ALPHA; w.b_sel = B_DIFF;
			end
			3'd2: w.op = OP_FILT;
			3'd3: w.op = OP_INTEG;
			3'd4: begin
				w.op = OP_MUL; w.mul_en = 1'b1; w.a_sel = A_KP; w.b_sel = B_FILT;
			end
			3'd5: begin
				w.op = OP_MUL_LOAD; w.mul_en = 1'b1; w.a_sel = A_KI; w.b_sel = B_INTEG;
			end
			3'd6: w.op = OP_ACC_ADD;
			3'd7: begin
				w.op = OP_EMIT; w.cond = COND_OUT_FULL; w.target = 3'd7;
			end
			default: w.op = OP_WAIT_IN;
		endcase
		return w;
	endfunction

endpackage

// File: src/filtered_pi_speed_controller.sv
`timescale 1ns / 1ps
// An accepted sample runs through the 8-step microprogram, which drives the single
// shared 25x26 multiplier, and is in the output register after the emit step; the
// next sample waits for that step, which holds while the output is stalled.
// Reset (arst_n low, asynchronous): gains, alpha and limit to their defaults,
// filter and integral state to zero, sequencer to its wait step, output empty.
module filtered_pi_speed_controller
	import fpsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // measured_speed[15:0], target_speed[31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // drive_value[31:0]
);

	logic signed [23:0] prop_gain_q, integ_gain_q;
	logic        [8:0]  alpha_q;
	logic        [15:0] limit_q;
	logic               out_valid_q;
	logic        [31:0] drive_q;

	ctrl_t              ctrl;
	stat_t              stat;
	logic               accept;
	logic               emit;
	logic signed [31:0] drive;

	assign s_axis_tready = (ctrl.op == OP_WAIT_IN);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign stat.in_valid = s_axis_tvalid;
	assign stat.out_full = out_valid_q && !m_axis_tready;

	assign emit = (ctrl.op == OP_EMIT) && !stat.out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			alpha_q      <= ALPHA_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_wr_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_wr_data;
				REG_ALPHA:      alpha_q      <= cfg_wr_data[8:0];
				REG_LIMIT:      limit_q      <= cfg_wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			drive_q <= drive;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;

	fpsc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	fpsc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.accept         (accept),
		.measured_speed (s_axis_tdata[15:0]),
		.target_speed   (s_axis_tdata[31:16]),
		.prop_gain      (prop_gain_q),
		.integ_gain     (integ_gain_q),
		.filter_alpha   (alpha_q),
		.integral_limit (limit_q),
		.drive          (drive)
	);

endmodule

// File: src/fpsc_seq.sv
`timescale 1ns / 1ps

module fpsc_seq
	import fpsc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic              hold;

	assign ctrl = fpsc_rom(step_q);

	always_comb begin
		case (ctrl.cond)
			COND_NO_INPUT: hold = !stat.in_valid;
			COND_OUT_FULL: hold = stat.out_full;
			default:       hold = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (hold) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// File: src/fpsc_dp.sv
`timescale 1ns / 1ps

module fpsc_dp
	import fpsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	input  logic               accept,
	input  logic signed [15:0] measured_speed,
	input  logic signed [15:0] target_speed,
	input  logic signed [23:0] prop_gain,
	input  logic signed [23:0] integ_gain,
	input  logic        [8:0]  filter_alpha,
	input  logic        [15:0] integral_limit,
	output logic signed [31:0] drive
);

	logic signed [25:0] filt_q, integ_q, diff_q;
	logic signed [50:0] prod_q, acc_q;

	logic signed [16:0] err;
	logic signed [25:0] e8;
	logic        [8:0]  alpha_eff;
	logic signed [24:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [50:0] prod_c;
	logic signed [26:0] isum, lim8;
	logic signed [25:0] integ_c;

	assign err = {measured_speed[15], measured_speed} - {target_speed[15], target_speed};
	assign e8  = {err[16], err, 8'b0};

	assign alpha_eff = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;

	always_comb begin
		case (ctrl.a_sel)
			A_KP:    mul_a = {prop_gain[23], prop_gain};
			A_KI:    mul_a = {integ_gain[23], integ_gain};
			default: mul_a = {16'b0, alpha_eff};
		endcase
		case (ctrl.b_sel)
			B_FILT:  mul_b = filt_q;
			B_INTEG: mul_b = integ_q;
			default: mul_b = diff_q;
		endcase
	end

	// signed 25x26 product, sign-extended to the accumulator width
	assign prod_c = mul_a * mul_b;

	// integral clamp to +/- limit in Q.8
	assign isum = {integ_q[25], integ_q} + {filt_q[25], filt_q};
	assign lim8 = {3'b0, integral_limit, 8'b0};
	always_comb begin
		if (isum > lim8) begin
			integ_c = lim8[25:0];
		end else if (isum < -lim8) begin
			integ_c = 26'(-lim8);
		end else begin
			integ_c = isum[25:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '0;
			integ_q <= '0;
		end else begin
			case (ctrl.op)
				OP_FILT:  filt_q  <= filt_q + prod_q[33:8];
				OP_INTEG: integ_q <= integ_c;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_WAIT_IN && accept) begin
			diff_q <= e8 - filt_q;
		end
		if (ctrl.mul_en) begin
			prod_q <= prod_c;
		end
		case (ctrl.op)
			OP_MUL_LOAD: acc_q <= prod_q;
			OP_ACC_ADD:  acc_q <= acc_q + prod_q;
			default: ;
		endcase
	end

	// floor(acc / 2^16), saturated to 32 bits
	always_comb begin
		if (acc_q[50:47] == {4{acc_q[47]}}) begin
			drive = acc_q[47:16];
		end else if (acc_q[50]) begin
			drive = DRIVE_MIN;
		end else begin
			drive = DRIVE_MAX;
		end
	end

endmodule
